// ===== rtl/core/lkvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants for the LRU key-value cache
// Slot count, derived index/rank/count widths, operation codes and the
// sequencer state type.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Number of slots in the store (1..256)
  localparam int unsigned Capacity = 16;

  // Slot index, recency rank and occupancy count widths
  localparam int unsigned IdxW  = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned CntW  = $clog2(Capacity + 1);

  // Fixed field widths
  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;
  localparam int unsigned CapW = 5;

  // Width that holds both the capacity register and the slot count
  localparam int unsigned LimW = (CntW > CapW) ? CntW : CapW;

  // Operation codes
  typedef enum logic {
    FuncGet = 1'b0,
    FuncSet = 1'b1
  } func_e;

  // Sequencer states
  typedef enum logic [1:0] {
    StIdle   = 2'd0,
    StScan   = 2'd1,
    StUpdate = 2'd2
  } state_e;

endpackage

// ===== rtl/core/lru_key_value_cache_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_core: fully associative key-value cache, LRU replacement
// One key comparator walks the slots under a small sequencer, then an
// update state writes the chosen slot and ages the recency ranks.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------
//  request   | start, busy               | func_i, lookup_key_i, write_value_i
//  result    | done_o (one-cycle strobe) | hit_o, read_value_o, evicted_o
//  config    | capacity_in_use_we_i      | capacity_in_use_i
//
//  A request is taken when start is high and busy is low. The scan walks
//  every slot in turn through the shared key comparator, then the update
//  state writes the chosen slot; the result strobe follows as the block
//  returns to idle, and no new request is taken before then.
//  Reset empties the store (valid bits, occupancy) and sets the capacity
//  register to 16. The result is presented for one cycle; the receiver
//  cannot stall it.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // request
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   func_i,
  input  logic signed [lkvc_pkg::KeyW-1:0]       lookup_key_i,
  input  logic signed [lkvc_pkg::ValW-1:0]       write_value_i,
  // result
  output logic                                   done_o,
  output logic                                   hit_o,
  output logic signed [lkvc_pkg::ValW-1:0]       read_value_o,
  output logic                                   evicted_o,
  // configuration
  input  logic                                   capacity_in_use_we_i,
  input  logic        [lkvc_pkg::CapW-1:0]       capacity_in_use_i
);

  // Sequencer
  lkvc_pkg::state_e state_q, state_d;
  logic             scan_en, upd_en, last_slot;

  // Captured request
  logic                          func_q;
  logic [lkvc_pkg::KeyW-1:0]     key_q;
  logic [lkvc_pkg::ValW-1:0]     val_q;

  // Storage
  logic [lkvc_pkg::KeyW-1:0]     key_store_q   [lkvc_pkg::Capacity];
  logic [lkvc_pkg::ValW-1:0]     value_store_q [lkvc_pkg::Capacity];
  logic [lkvc_pkg::Capacity-1:0] valid_q, valid_d;
  logic [lkvc_pkg::RankW-1:0]    rank_q [lkvc_pkg::Capacity];
  logic [lkvc_pkg::RankW-1:0]    rank_d [lkvc_pkg::Capacity];
  logic [lkvc_pkg::CntW-1:0]     occ_q;
  logic [lkvc_pkg::CapW-1:0]     cap_q;

  // Scan bookkeeping
  logic [lkvc_pkg::IdxW-1:0]     idx_q;
  logic                          found_v_q, oldest_v_q, free_v_q;
  logic [lkvc_pkg::IdxW-1:0]     found_q, oldest_q, free_q;
  logic [lkvc_pkg::RankW-1:0]    oldest_rank_q;
  logic                          key_match, is_oldest;

  // Update decision
  logic [lkvc_pkg::LimW-1:0]     cap_ext, limit;
  logic                          is_set, full, do_alloc, do_evict, do_write, do_promote;
  logic                          was_valid;
  logic [lkvc_pkg::IdxW-1:0]     tgt;

  // Result registers
  logic                          done_q, hit_q, ev_q;
  logic [lkvc_pkg::ValW-1:0]     rd_q;

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  assign last_slot = (idx_q == lkvc_pkg::IdxW'(lkvc_pkg::Capacity - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkvc_pkg::StIdle:   if (start) state_d = lkvc_pkg::StScan;
      lkvc_pkg::StScan:   if (last_slot) state_d = lkvc_pkg::StUpdate;
      lkvc_pkg::StUpdate: state_d = lkvc_pkg::StIdle;
      default:            state_d = lkvc_pkg::StIdle;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    busy    = 1'b1;
    scan_en = 1'b0;
    upd_en  = 1'b0;
    unique case (state_q)
      lkvc_pkg::StIdle:   busy = 1'b0;
      lkvc_pkg::StScan:   scan_en = 1'b1;
      lkvc_pkg::StUpdate: upd_en = 1'b1;
      default:            busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Request capture on transfer
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      func_q <= func_i;
      key_q  <= lookup_key_i;
      val_q  <= write_value_i;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CapW'(16);
    end else if (capacity_in_use_we_i) begin
      cap_q <= capacity_in_use_i;
    end
  end

  // --------------------------------------------------------------------------
  // Scan: one slot per cycle through the shared comparator
  // --------------------------------------------------------------------------
  assign key_match = valid_q[idx_q] && (key_store_q[idx_q] == key_q);
  assign is_oldest = valid_q[idx_q] && (!oldest_v_q || (rank_q[idx_q] >= oldest_rank_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      found_v_q  <= 1'b0;
      oldest_v_q <= 1'b0;
      free_v_q   <= 1'b0;
    end else if (start && !busy) begin
      idx_q      <= '0;
      found_v_q  <= 1'b0;
      oldest_v_q <= 1'b0;
      free_v_q   <= 1'b0;
    end else if (scan_en) begin
      idx_q <= last_slot ? '0 : idx_q + 1'b1;
      if (key_match && !found_v_q) found_v_q <= 1'b1;
      if (is_oldest) oldest_v_q <= 1'b1;
      if (!valid_q[idx_q] && !free_v_q) free_v_q <= 1'b1;
    end
  end

  // Scan payload (indices and rank of the candidates)
  always_ff @(posedge clk_i) begin
    if (scan_en) begin
      if (key_match && !found_v_q) found_q <= idx_q;
      if (is_oldest) begin
        oldest_q      <= idx_q;
        oldest_rank_q <= rank_q[idx_q];
      end
      if (!valid_q[idx_q] && !free_v_q) free_q <= idx_q;
    end
  end

  // --------------------------------------------------------------------------
  // Update decision
  // --------------------------------------------------------------------------
  // Capacity of zero acts as one, above the slot count as the slot count
  assign cap_ext = lkvc_pkg::LimW'(cap_q);
  always_comb begin
    if (cap_ext == '0) begin
      limit = lkvc_pkg::LimW'(1);
    end else if (cap_ext > lkvc_pkg::LimW'(lkvc_pkg::Capacity)) begin
      limit = lkvc_pkg::LimW'(lkvc_pkg::Capacity);
    end else begin
      limit = cap_ext;
    end
  end

  assign is_set     = (func_q == lkvc_pkg::FuncSet);
  assign full       = (lkvc_pkg::LimW'(occ_q) >= limit) || !free_v_q;
  assign do_alloc   = upd_en && is_set && !found_v_q && !full;
  assign do_evict   = upd_en && is_set && !found_v_q && full && oldest_v_q;
  assign do_write   = (upd_en && is_set && found_v_q) || do_alloc || do_evict;
  assign do_promote = (upd_en && found_v_q) || do_alloc || do_evict;
  assign was_valid  = !do_alloc;

  always_comb begin
    if (found_v_q) begin
      tgt = found_q;
    end else if (full) begin
      tgt = oldest_q;
    end else begin
      tgt = free_q;
    end
  end

  // Promotion: younger valid entries age by one, target becomes rank zero
  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
      rank_d[i] = rank_q[i];
      if (do_promote) begin
        if (lkvc_pkg::IdxW'(i) == tgt) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (!was_valid || (rank_q[i] < rank_q[tgt]))) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
    end
    if (do_alloc) valid_d[tgt] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      for (int i = 0; i < lkvc_pkg::Capacity; i++) rank_q[i] <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
      if (do_alloc) occ_q <= occ_q + 1'b1;
    end
  end

  // Store write
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      key_store_q[tgt]   <= key_q;
      value_store_q[tgt] <= val_q;
    end
  end

  // --------------------------------------------------------------------------
  // Result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= upd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_en) begin
      hit_q <= found_v_q;
      ev_q  <= do_evict;
      rd_q  <= (found_v_q && !is_set) ? value_store_q[found_q] : '0;
    end
  end

  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign evicted_o    = ev_q;
  assign read_value_o = rd_q;

endmodule

// ===== rtl/core/lkvc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks for the LRU key-value cache
// Watches the request/result handshake and the result encoding.
// ----------------------------------------------------------------------------
module lkvc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic                                done_o,
  input logic                                hit_o,
  input logic signed [lkvc_pkg::ValW-1:0]    read_value_o,
  input logic                                evicted_o
);

  // A transfer starts a multi-cycle operation
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after transfer");

  // The result strobe comes only once the operation has finished
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // One result per transfer: the strobe lasts a single cycle
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  // A hit, whether a read or an update of a present key, never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_o))
    else $error("hit and eviction reported together");

  // Miss reads back zero
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hit_o) |-> (read_value_o == '0))
    else $error("nonzero read value on miss");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .hit_o        (hit_o),
  .read_value_o (read_value_o),
  .evicted_o    (evicted_o)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lru_key_value_cache_core
// Drives get/set requests and capacity register writes. A local LRU
// predictor computes each result, and every result strobe is checked
// field by field against the oldest expectation waiting.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned PhaseCount    = 13;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned PoolMax       = 24;
  localparam int unsigned DrainCycles   = lkvc_pkg::Capacity + 6;
  localparam int unsigned DirRows       = 23;

  localparam logic [lkvc_pkg::KeyW-1:0] KeyMin  = 32'h8000_0000;
  localparam logic [lkvc_pkg::KeyW-1:0] KeyMax  = 32'h7fff_ffff;
  localparam logic [lkvc_pkg::KeyW-1:0] AllOnes = 32'hffff_ffff;

  typedef enum logic {
    RowAccess = 1'b0,
    RowConfig = 1'b1
  } row_kind_e;

  typedef struct packed {
    logic                      hit;
    logic [lkvc_pkg::ValW-1:0] read_value;
    logic                      evicted;
  } cache_result_t;

  typedef struct packed {
    row_kind_e                 kind;
    lkvc_pkg::func_e           func;
    logic [lkvc_pkg::KeyW-1:0] key;
    logic [lkvc_pkg::ValW-1:0] value;
    logic                      typed;
    cache_result_t             want;
  } stim_row_t;

  // DUT signals
  logic                             clk_i;
  logic                             rst_ni = 1'b0;
  logic                             start = 1'b0;
  logic                             busy;
  logic                             func_i = 1'b0;
  logic signed [lkvc_pkg::KeyW-1:0] lookup_key_i = '0;
  logic signed [lkvc_pkg::ValW-1:0] write_value_i = '0;
  logic                             done_o;
  logic                             hit_o;
  logic signed [lkvc_pkg::ValW-1:0] read_value_o;
  logic                             evicted_o;
  logic                             capacity_in_use_we_i = 1'b0;
  logic [lkvc_pkg::CapW-1:0]        capacity_in_use_i = '0;

  // Predictor state: a shadow copy of the store
  logic [lkvc_pkg::KeyW-1:0] shadow_key   [lkvc_pkg::Capacity];
  logic [lkvc_pkg::ValW-1:0] shadow_val   [lkvc_pkg::Capacity];
  logic                      shadow_valid [lkvc_pkg::Capacity];
  int unsigned               shadow_rank  [lkvc_pkg::Capacity];
  int unsigned               shadow_occ;
  logic [lkvc_pkg::CapW-1:0] shadow_cap;

  // Expected results in order: written at transfer, read at the strobe
  cache_result_t   exp_fifo [4];
  int unsigned     exp_wr_cnt = 0;
  int unsigned     exp_rd_cnt = 0;
  cache_result_t   oldest_pending;
  stim_row_t       directed_rows [DirRows];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;
  bit              steady_phase = 1'b0;

  lru_key_value_cache_core i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .func_i               (func_i),
    .lookup_key_i         (lookup_key_i),
    .write_value_i        (write_value_i),
    .done_o               (done_o),
    .hit_o                (hit_o),
    .read_value_o         (read_value_o),
    .evicted_o            (evicted_o),
    .capacity_in_use_we_i (capacity_in_use_we_i),
    .capacity_in_use_i    (capacity_in_use_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("lru_key_value_cache_core: mismatch");
      $finish;
    end
  end

  // Capacity as the block applies it: 0 acts as 1, above Capacity clamps
  function automatic int unsigned slot_limit();
    int unsigned lim;
    lim = 32'(shadow_cap);
    if (lim == 0) lim = 1;
    if (lim > lkvc_pkg::Capacity) lim = lkvc_pkg::Capacity;
    return lim;
  endfunction

  // Make slot s most recent; younger valid slots age by one
  function automatic void make_recent(int unsigned s, bit was_valid);
    int unsigned r;
    r = was_valid ? shadow_rank[s] : lkvc_pkg::Capacity;
    for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
      if (i != s && shadow_valid[i] && shadow_rank[i] < r) shadow_rank[i]++;
    end
    shadow_rank[s] = 0;
  endfunction

  // LRU lookup/insert on the shadow store, returns the expected result
  function automatic cache_result_t lru_access(lkvc_pkg::func_e f,
                                               logic [lkvc_pkg::KeyW-1:0] key,
                                               logic [lkvc_pkg::ValW-1:0] val);
    cache_result_t res;
    int unsigned   found;
    int unsigned   free_slot;
    int unsigned   victim;
    int unsigned   victim_rank;
    res = '0;
    found = lkvc_pkg::Capacity;
    free_slot = lkvc_pkg::Capacity;
    victim = lkvc_pkg::Capacity;
    victim_rank = 0;
    for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
      if (shadow_valid[i]) begin
        if (found == lkvc_pkg::Capacity && shadow_key[i] == key) found = i;
        if (victim == lkvc_pkg::Capacity || shadow_rank[i] >= victim_rank) begin
          victim = i;
          victim_rank = shadow_rank[i];
        end
      end else if (free_slot == lkvc_pkg::Capacity) begin
        free_slot = i;
      end
    end
    if (found < lkvc_pkg::Capacity) begin
      res.hit = 1'b1;
      if (f == lkvc_pkg::FuncGet) res.read_value = shadow_val[found];
      else shadow_val[found] = val;
      make_recent(found, 1'b1);
    end else if (f == lkvc_pkg::FuncSet) begin
      if (shadow_occ >= slot_limit() || free_slot >= lkvc_pkg::Capacity) begin
        if (victim < lkvc_pkg::Capacity) begin
          shadow_key[victim] = key;
          shadow_val[victim] = val;
          make_recent(victim, 1'b1);
          res.evicted = 1'b1;
        end
      end else begin
        shadow_key[free_slot] = key;
        shadow_val[free_slot] = val;
        make_recent(free_slot, 1'b0);
        shadow_valid[free_slot] = 1'b1;
        shadow_occ++;
      end
    end
    return res;
  endfunction

  function automatic stim_row_t mk_row(row_kind_e kind, lkvc_pkg::func_e f,
                                       logic [lkvc_pkg::KeyW-1:0] key,
                                       logic [lkvc_pkg::ValW-1:0] val, logic typed,
                                       logic hit, logic [lkvc_pkg::ValW-1:0] rd,
                                       logic ev);
    stim_row_t row;
    row.kind = kind;
    row.func = f;
    row.key = key;
    row.value = val;
    row.typed = typed;
    row.want.hit = hit;
    row.want.read_value = rd;
    row.want.evicted = ev;
    return row;
  endfunction

  // One request transfer; called and returning at a rising edge
  task automatic send_request(input lkvc_pkg::func_e f,
                              input logic [lkvc_pkg::KeyW-1:0] key,
                              input logic [lkvc_pkg::ValW-1:0] val, input logic typed,
                              input cache_result_t want);
    cache_result_t predicted;
    start         <= 1'b1;
    func_i        <= f;
    lookup_key_i  <= key;
    write_value_i <= val;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predicted = lru_access(f, key, val);
    exp_fifo[exp_wr_cnt[1:0]] = typed ? want : predicted;
    exp_wr_cnt++;
  endtask

  // Random gap between requests
  task automatic maybe_pause();
    if (!steady_phase && $urandom_range(0, 99) < 35) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  endtask

  // Capacity write once the block is idle and all results are in
  task automatic write_capacity(input logic [lkvc_pkg::CapW-1:0] cap);
    start <= 1'b0;
    @(negedge clk_i);
    while (exp_wr_cnt != exp_rd_cnt || busy) @(negedge clk_i);
    @(posedge clk_i);
    capacity_in_use_we_i <= 1'b1;
    capacity_in_use_i    <= cap;
    @(posedge clk_i);
    capacity_in_use_we_i <= 1'b0;
    shadow_cap = cap;
  endtask

  // Result checker, sampled mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni && done_o) begin
      if (exp_wr_cnt == exp_rd_cnt) begin
        mismatch_count++;
        $display("%0t: result with nothing expected: hit %0b read_value %0h evicted %0b",
                 $realtime, hit_o, read_value_o, evicted_o);
      end else begin
        oldest_pending = exp_fifo[exp_rd_cnt[1:0]];
        exp_rd_cnt++;
        if (hit_o !== oldest_pending.hit) begin
          mismatch_count++;
          $display("%0t: hit expected %0b actual %0b", $realtime, oldest_pending.hit, hit_o);
        end
        if (read_value_o !== oldest_pending.read_value) begin
          mismatch_count++;
          $display("%0t: read_value expected %0h actual %0h", $realtime,
                   oldest_pending.read_value, read_value_o);
        end
        if (evicted_o !== oldest_pending.evicted) begin
          mismatch_count++;
          $display("%0t: evicted expected %0b actual %0b", $realtime,
                   oldest_pending.evicted, evicted_o);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [lkvc_pkg::KeyW-1:0] key_pool [PoolMax];
    int unsigned               pool_size;
    int unsigned               set_pct;
    logic [lkvc_pkg::CapW-1:0] cap;
    logic [lkvc_pkg::KeyW-1:0] key;
    lkvc_pkg::func_e           f;
    stim_row_t                 row;

    // Shadow store after reset
    for (int i = 0; i < lkvc_pkg::Capacity; i++) begin
      shadow_key[i] = '0;
      shadow_val[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_occ = 0;
    shadow_cap = 5'd16;

    // Directed table: typed results where obvious, predictor elsewhere
    directed_rows = '{
      mk_row(RowAccess, lkvc_pkg::FuncGet, '0, AllOnes, 1'b1, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncSet, KeyMin, KeyMax, 1'b1, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncSet, KeyMax, KeyMin, 1'b1, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncGet, KeyMin, '0, 1'b1, 1'b1, KeyMax, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncGet, KeyMax, '0, 1'b1, 1'b1, KeyMin, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncSet, KeyMin, '0, 1'b1, 1'b1, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncGet, KeyMin, AllOnes, 1'b1, 1'b1, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncGet, 32'd1, '0, 1'b1, 1'b0, '0, 1'b0),
      // capacity lowered below occupancy
      mk_row(RowConfig, lkvc_pkg::FuncGet, '0, 32'd1, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncSet, 32'd5, 32'd55, 1'b1, 1'b0, '0, 1'b1),
      mk_row(RowAccess, lkvc_pkg::FuncGet, KeyMax, '0, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncGet, 32'd5, '0, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncSet, 32'd6, 32'd66, 1'b0, 1'b0, '0, 1'b0),
      // zero capacity acts as one
      mk_row(RowConfig, lkvc_pkg::FuncGet, '0, 32'd0, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncSet, 32'd7, AllOnes, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncGet, 32'd6, '0, 1'b0, 1'b0, '0, 1'b0),
      // oversized capacity clamps to the slot count
      mk_row(RowConfig, lkvc_pkg::FuncGet, '0, 32'd31, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncSet, AllOnes, 32'ha5a5_a5a5, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncSet, 32'd9, 32'h5a5a_5a5a, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncGet, AllOnes, '0, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowConfig, lkvc_pkg::FuncGet, '0, 32'd16, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncSet, 32'd7, KeyMax, 1'b0, 1'b0, '0, 1'b0),
      mk_row(RowAccess, lkvc_pkg::FuncGet, 32'd7, '0, 1'b0, 1'b0, '0, 1'b0)
    };

    // Hold reset low, then release it
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == RowConfig) begin
        write_capacity(row.value[lkvc_pkg::CapW-1:0]);
      end else begin
        send_request(row.func, row.key, row.value, row.typed, row.want);
        maybe_pause();
      end
    end

    // Random phases, each under its own capacity setting
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0:       cap = 5'd16;
        1:       cap = 5'd1;
        2:       cap = 5'd0;
        3:       cap = 5'd31;
        4:       cap = 5'd2;
        5:       cap = 5'd15;
        default: cap = lkvc_pkg::CapW'($urandom_range(0, 31));
      endcase
      write_capacity(cap);
      steady_phase = (phase == 3);
      pool_size = slot_limit() + $urandom_range(1, 8);
      if (pool_size > PoolMax) pool_size = PoolMax;
      for (int i = 0; i < PoolMax; i++) key_pool[i] = $urandom();
      if (phase == 6) begin
        key_pool[0] = KeyMin;
        key_pool[1] = KeyMax;
        key_pool[2] = '0;
        key_pool[3] = AllOnes;
      end
      set_pct = $urandom_range(30, 70);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(0, 99) < 10) key = $urandom();
        else key = key_pool[$urandom_range(0, pool_size - 1)];
        f = ($urandom_range(0, 99) < set_pct) ? lkvc_pkg::FuncSet : lkvc_pkg::FuncGet;
        send_request(f, key, $urandom(), 1'b0, '0);
        maybe_pause();
      end
    end
    steady_phase = 1'b0;

    // Drain
    start <= 1'b0;
    @(negedge clk_i);
    while (exp_wr_cnt != exp_rd_cnt) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("lru_key_value_cache_core: match");
    end else begin
      $display("lru_key_value_cache_core: mismatch");
    end
    $finish;
  end

endmodule
